// ===== rtl/rars_pkg.sv =====
// Shared types and constants for the rotor angle row selector.
// Holds transaction structs, register indexes, fixed-point constants
// and divider control structs. Depends on nothing.
package rars_pkg;

   // Image height default and fixed-point layout
   localparam int IMAGE_ROWS_DEFAULT = 128;
   localparam int FRAC_BITS          = 20;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_INTERVAL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ALPHA = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ANGLE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPREAD       = 3'd4;

   // Register widths and reset values
   localparam int ALPHA_W = 17;
   localparam int DEG_W   = 8;
   localparam logic [31:0]        MIN_INTERVAL_RESET = 32'd60000;
   localparam logic [31:0]        MAX_INTERVAL_RESET = 32'd1000000;
   localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RESET = 17'd13107;
   localparam logic [DEG_W-1:0]   START_ANGLE_RESET  = 8'd40;
   localparam logic [DEG_W-1:0]   SPREAD_RESET       = 8'd120;

   // Item operation codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Filter constants
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
   localparam int                 SUM_W       = 49;
   localparam logic [SUM_W-1:0]   FILTER_ROUND = 49'd32768;

   // Angle constants, degrees in Q.20
   localparam int ANG_W = 29;
   localparam int D_W   = 28;
   localparam logic [ANG_W-1:0] ANGLE_SCALE = 29'd377487360;  // 360 << 20
   localparam logic [ANG_W-1:0] HALF_TURN   = 29'd188743680;  // 180 << 20

   // Shared multiplier operand widths
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 29;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Shared divider widths
   localparam int DIV_DVD_W   = 64;
   localparam int DIV_DSR_W   = 32;
   localparam int DIV_STEPS_W = 7;
   localparam logic [DIV_STEPS_W-1:0] REM_STEPS = 7'd40;
   localparam logic [DIV_STEPS_W-1:0] ANG_STEPS = 7'd61;

   typedef struct packed {
      logic        op;
      logic [31:0] time_us;
   } rars_req_type;

   typedef struct packed {
      logic        tick_accepted;
      logic [6:0]  row_index;
      logic        row_valid;
      logic [31:0] period_q8;
   } rars_rsp_type;

   typedef struct packed {
      logic                   start;
      logic [DIV_STEPS_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/rotor_angle_row_select.sv =====
// Rotor angle row selector: top level, sequencer, registers and datapath.
// Instantiates rars_div_unit; depends on rars_pkg.
//
// Usage
//   req channel (req_valid / req_stall / req_data): one transaction per
//   item, op = tick or query, with a wrapping microsecond timestamp.
//   rsp channel (rsp_valid / rsp_stall / rsp_data): exactly one transaction
//   per request, in order, carrying the filtered period after that item.
//   csr channel (csr_valid / csr_ready / csr_index / csr_wdata): register
//   writes, always ready; write only while no request is in flight.
// Sequencing
//   One request at a time. A rejected tick, or an accepted tick whose
//   interval exceeds the maximum, skips the filter update. A query runs
//   three divisions on the shared one-bit-per-cycle divider (40, 61 and
//   28 + clog2(rows+1) steps). A query with zero period or spread skips
//   the divisions. req_stall is high whenever a request is busy.
// Reset
//   Synchronous, active high: registers to their defaults, last tick time
//   and filtered period to zero, no response pending.
// Stall
//   A finished result waits in the output register while rsp_stall is
//   high; the next request is taken meanwhile and holds before its result.
module rotor_angle_row_select #(
   parameter int IMAGE_ROWS = rars_pkg::IMAGE_ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rars_pkg::rars_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rars_pkg::rars_rsp_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rars_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                        csr_wdata
);
   import rars_pkg::*;

   // Row arithmetic widths follow the image height
   localparam int ROWS_VAL_W = $clog2(IMAGE_ROWS + 1);
   localparam int ROW_W      = $clog2(IMAGE_ROWS);
   localparam int PROD_W     = D_W + ROWS_VAL_W;
   localparam int ROW_FULL_W = PROD_W + 1 - FRAC_BITS;
   localparam logic [DIV_STEPS_W-1:0] ROW_STEPS = DIV_STEPS_W'(PROD_W);
   localparam logic [MUL_B_W-1:0]     ROWS_MUL  = MUL_B_W'(IMAGE_ROWS);
   localparam logic [PROD_W-1:0]      ROWS_Q    = PROD_W'(IMAGE_ROWS) << FRAC_BITS;
   localparam logic [PROD_W:0]        ROW_ROUND = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic [ROW_FULL_W-1:0]  ROWS_FULL = ROW_FULL_W'(IMAGE_ROWS);
   localparam logic [ROW_W-1:0]       ROW_LAST  = ROW_W'(IMAGE_ROWS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T_CHECK,
      ST_T_MUL_NEW,
      ST_T_MUL_OLD,
      ST_T_SUM,
      ST_Q_CHECK,
      ST_Q_DIV_WAIT,
      ST_Q_MUL_ANG,
      ST_Q_LOAD_ANG,
      ST_Q_FOLD,
      ST_Q_MUL_ROW,
      ST_Q_LOAD_ROW,
      ST_Q_ROW,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_REM,
      PH_ANG,
      PH_ROW
   } phase_type;

   // Configuration registers
   logic [31:0]        min_ff;
   logic [31:0]        max_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [DEG_W-1:0]   start_ff;
   logic [DEG_W-1:0]   spread_ff;

   // Block state
   logic [31:0]        last_tick_ff;
   logic [31:0]        period_ff;

   // Sequencer and working registers
   state_type          state_ff;
   phase_type          phase_ff;
   logic [31:0]        time_ff;
   logic [31:0]        x_ff;
   logic [MUL_P_W-1:0] mul_ff;
   logic [47:0]        acc_ff;
   logic [D_W-1:0]     d_ff;

   // Result registers
   logic               res_acc_ff;
   logic               res_valid_ff;
   logic [ROW_W-1:0]   res_row_ff;
   logic               rsp_valid_ff;
   rars_rsp_type       rsp_ff;

   // Datapath signals
   logic [31:0]          x_in;
   logic [31:0]          elapsed;
   logic [31:0]          xq;
   logic [ALPHA_W-1:0]   alpha_c;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_in;
   logic [SUM_W-1:0]     sum;
   logic                 query_blank;
   logic [ANG_W-1:0]     ang;
   logic [ANG_W-1:0]     ang_f;
   logic [ANG_W-1:0]     base;
   logic [ANG_W-1:0]     d_wide;
   logic [PROD_W-1:0]    yq;
   logic [PROD_W:0]      row_sum;
   logic [ROW_FULL_W-1:0] row_full;
   logic [ROW_W-1:0]     row_in;
   logic [ROW_W+6:0]     row_ext;
   logic                 req_take;

   div_cmd_type          div_cmd;
   div_status_type       div_status;
   logic [DIV_DVD_W-1:0] div_dvd;
   logic [DIV_DSR_W-1:0] div_dsr;
   logic [DIV_DVD_W-1:0] div_quo;
   logic [DIV_DSR_W-1:0] div_rem;

   rars_div_unit u_div (
      .clock      (clock),
      .reset      (reset),
      .div_cmd    (div_cmd),
      .dividend   (div_dvd),
      .divisor    (div_dsr),
      .div_status (div_status),
      .quotient   (div_quo),
      .remainder  (div_rem)
   );

   assign req_take = req_valid && !req_stall;

   // Interval arithmetic and filter operands
   always_comb begin
      x_in        = time_ff - last_tick_ff;
      elapsed     = time_ff - last_tick_ff;
      // saturate Q24.8 form once the interval no longer fits 24 bits
      xq          = (x_ff[31:24] != '0) ? 32'hFFFF_FFFF : {x_ff[23:0], 8'h00};
      alpha_c     = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      sum         = {1'b0, acc_ff} + {1'b0, mul_ff[47:0]} + FILTER_ROUND;
      query_blank = (period_ff == '0) || (spread_ff == '0);
   end

   // Shared multiplier: pick operands by step
   always_comb begin
      unique case (state_ff)
         ST_T_MUL_NEW: begin
            mul_a = xq;
            mul_b = {{(MUL_B_W - ALPHA_W){1'b0}}, alpha_c};
         end
         ST_T_MUL_OLD: begin
            mul_a = period_ff;
            mul_b = {{(MUL_B_W - ALPHA_W){1'b0}}, ALPHA_ONE - alpha_c};
         end
         ST_Q_MUL_ANG: begin
            mul_a = div_rem;
            mul_b = ANGLE_SCALE;
         end
         ST_Q_MUL_ROW: begin
            mul_a = {{(MUL_A_W - D_W){1'b0}}, d_ff};
            mul_b = ROWS_MUL;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_in = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
   end

   // Divider launch: remainder of the turn, angle, then row
   always_comb begin
      div_cmd.start = 1'b0;
      div_cmd.steps = REM_STEPS;
      div_dvd       = {elapsed, 32'h0000_0000};
      div_dsr       = period_ff;
      unique case (state_ff)
         ST_Q_CHECK: begin
            div_cmd.start = !query_blank;
         end
         ST_Q_LOAD_ANG: begin
            div_cmd.start = 1'b1;
            div_cmd.steps = ANG_STEPS;
            div_dvd       = {mul_ff, {(DIV_DVD_W - MUL_P_W){1'b0}}};
         end
         ST_Q_LOAD_ROW: begin
            div_cmd.start = 1'b1;
            div_cmd.steps = ROW_STEPS;
            div_dvd       = {mul_ff[PROD_W-1:0], {(DIV_DVD_W - PROD_W){1'b0}}};
            div_dsr       = {{(DIV_DSR_W - DEG_W){1'b0}}, spread_ff};
         end
         default: begin
            div_cmd.start = 1'b0;
         end
      endcase
   end

   // Fold to a half-turn, offset by the start angle, round the row half up
   always_comb begin
      ang      = div_quo[ANG_W-1:0];
      ang_f    = (ang >= HALF_TURN) ? ang - HALF_TURN : ang;
      base     = {{(ANG_W - DEG_W - FRAC_BITS){1'b0}}, start_ff, {FRAC_BITS{1'b0}}};
      d_wide   = ang_f - base;
      yq       = div_quo[PROD_W-1:0];
      row_sum  = {1'b0, yq} + ROW_ROUND;
      row_full = row_sum[PROD_W:FRAC_BITS];
      row_in   = (row_full >= ROWS_FULL) ? ROW_LAST : row_full[ROW_W-1:0];
      row_ext  = {7'b000_0000, res_row_ff};
   end

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= MIN_INTERVAL_RESET;
         max_ff    <= MAX_INTERVAL_RESET;
         alpha_ff  <= FILTER_ALPHA_RESET;
         start_ff  <= START_ANGLE_RESET;
         spread_ff <= SPREAD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_INTERVAL: min_ff    <= csr_wdata;
            CSR_MAX_INTERVAL: max_ff    <= csr_wdata;
            CSR_FILTER_ALPHA: alpha_ff  <= csr_wdata[ALPHA_W-1:0];
            CSR_START_ANGLE:  start_ff  <= csr_wdata[DEG_W-1:0];
            CSR_SPREAD:       spread_ff <= csr_wdata[DEG_W-1:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   // Sequencer with its registered outputs
   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_REM;
         last_tick_ff <= '0;
         period_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // retire the waiting response once taken
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  time_ff      <= req_data.time_us;
                  res_acc_ff   <= 1'b0;
                  res_valid_ff <= 1'b0;
                  res_row_ff   <= '0;
                  state_ff     <= (req_data.op == OP_QUERY) ? ST_Q_CHECK : ST_T_CHECK;
               end
            end
            ST_T_CHECK: begin
               if (x_in < min_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  last_tick_ff <= time_ff;
                  x_ff         <= x_in;
                  res_acc_ff   <= 1'b1;
                  state_ff     <= (x_in <= max_ff) ? ST_T_MUL_NEW : ST_DONE;
               end
            end
            ST_T_MUL_NEW: begin
               state_ff <= ST_T_MUL_OLD;
            end
            ST_T_MUL_OLD: begin
               acc_ff   <= mul_ff[47:0];
               state_ff <= ST_T_SUM;
            end
            ST_T_SUM: begin
               period_ff <= sum[47:16];
               state_ff  <= ST_DONE;
            end
            ST_Q_CHECK: begin
               phase_ff <= PH_REM;
               state_ff <= query_blank ? ST_DONE : ST_Q_DIV_WAIT;
            end
            ST_Q_DIV_WAIT: begin
               if (div_status.done) begin
                  unique case (phase_ff)
                     PH_REM:  state_ff <= ST_Q_MUL_ANG;
                     PH_ANG:  state_ff <= ST_Q_FOLD;
                     PH_ROW:  state_ff <= ST_Q_ROW;
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_Q_MUL_ANG: begin
               state_ff <= ST_Q_LOAD_ANG;
            end
            ST_Q_LOAD_ANG: begin
               phase_ff <= PH_ANG;
               state_ff <= ST_Q_DIV_WAIT;
            end
            ST_Q_FOLD: begin
               if (ang_f < base) begin
                  state_ff <= ST_DONE;
               end else begin
                  d_ff     <= d_wide[D_W-1:0];
                  state_ff <= ST_Q_MUL_ROW;
               end
            end
            ST_Q_MUL_ROW: begin
               state_ff <= ST_Q_LOAD_ROW;
            end
            ST_Q_LOAD_ROW: begin
               phase_ff <= PH_ROW;
               state_ff <= ST_Q_DIV_WAIT;
            end
            ST_Q_ROW: begin
               // blank beyond the image; the bottom edge clamps to the last row
               if (yq <= ROWS_Q) begin
                  res_valid_ff <= 1'b1;
                  res_row_ff   <= row_in;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.tick_accepted <= res_acc_ff;
                  rsp_ff.row_index     <= row_ext[6:0];
                  rsp_ff.row_valid     <= res_valid_ff;
                  rsp_ff.period_q8     <= period_ff;
                  rsp_valid_ff         <= 1'b1;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_row_only_query : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.row_valid |-> !rsp_ff.tick_accepted)
      else $error("row shown on a tick transaction");

   a_last_tick_src : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && last_tick_ff != $past(last_tick_ff) |->
         $past(state_ff) == ST_T_CHECK)
      else $error("last tick time changed outside tick check");

   a_period_src : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && period_ff != $past(period_ff) |->
         $past(state_ff) == ST_T_SUM)
      else $error("period changed outside filter update");

   a_take_busy : assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("request taken but sequencer stayed idle");

endmodule

// ===== rtl/rars_div_unit.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Dividend is given left-aligned; the step count sets the quotient width.
// Depends on rars_pkg.
module rars_div_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  rars_pkg::div_cmd_type              div_cmd,
   input  logic [rars_pkg::DIV_DVD_W-1:0]     dividend,
   input  logic [rars_pkg::DIV_DSR_W-1:0]     divisor,
   output rars_pkg::div_status_type           div_status,
   output logic [rars_pkg::DIV_DVD_W-1:0]     quotient,
   output logic [rars_pkg::DIV_DSR_W-1:0]     remainder
);
   import rars_pkg::*;

   logic [DIV_DVD_W-1:0]   dvd_ff;
   logic [DIV_DSR_W-1:0]   rem_ff;
   logic [DIV_DSR_W-1:0]   dsr_ff;
   logic [DIV_STEPS_W-1:0] cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;

   logic [DIV_DSR_W:0]     trial;
   logic [DIV_DSR_W:0]     diff;
   logic                   fits;
   logic [DIV_DSR_W-1:0]   rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[DIV_DVD_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = (trial >= {1'b0, dsr_ff});
      rem_in = fits ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_cmd.start) begin
            dvd_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
            cnt_ff  <= div_cmd.steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[DIV_DVD_W-2:0], fits};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_STEPS_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_status.busy = busy_ff;
   assign div_status.done = done_ff;
   assign quotient        = dvd_ff;
   assign remainder       = rem_ff;

   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !busy_ff)
      else $error("divider started while busy");

   a_count_live : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with no steps left");

   a_last_step : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !div_cmd.start && cnt_ff == DIV_STEPS_W'(1) |=> done_ff && !busy_ff)
      else $error("divider failed to finish after last step");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      done_ff && dsr_ff != '0 |-> rem_ff < dsr_ff)
      else $error("divider remainder not below divisor");

endmodule
